/* hw/rtl/partition_table_fit_allocator_unit_assert.svh */
// Assertion macros used by the partition table fit allocator controller.
`ifndef PARTITION_TABLE_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define PARTITION_TABLE_FIT_ALLOCATOR_UNIT_ASSERT_SVH

// Checks that a condition holds at every clock edge out of reset.
`define PTFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a trigger is followed by a consequence in the next cycle.
`define PTFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ptfa_pkg.sv */
// Package with constants, status codes and control types of the partition allocator.
package ptfa_pkg;

  localparam int TABLE_SLOTS = 4;
  localparam int OFFSET_BITS = 48;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int SIZE_W      = 31;
  localparam int UNIT_SHIFT  = 10;
  localparam int BYTE_W      = SIZE_W + 2 * UNIT_SHIFT;
  localparam int CMP_W       = (BYTE_W > OFFSET_BITS) ? BYTE_W : OFFSET_BITS;
  localparam int NAME_LO_W   = 64;
  localparam int NAME_HI_W   = 56;
  localparam int DISK_W      = 48;
  localparam int HDR_W       = 16;
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 4;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_BAD_SIZE   = 4'd1,
    ST_BAD_UNIT   = 4'd2,
    ST_BAD_TYPE   = 4'd3,
    ST_EXT_EXISTS = 4'd4,
    ST_LIMIT      = 4'd5,
    ST_NO_EXT     = 4'd6,
    ST_LOGICAL    = 4'd7,
    ST_DUPLICATE  = 4'd8,
    ST_NO_SLOT    = 4'd9,
    ST_NO_SPACE   = 4'd10
  } status_e;

  typedef enum logic [1:0] {
    UNIT_BYTES = 2'd0,
    UNIT_KIB   = 2'd1,
    UNIT_MIB   = 2'd2,
    UNIT_BAD   = 2'd3
  } unit_e;

  typedef enum logic [1:0] {
    KIND_PRIMARY  = 2'd0,
    KIND_EXTENDED = 2'd1,
    KIND_LOGICAL  = 2'd2,
    KIND_BAD      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    FIT_DEFAULT = 2'd0,
    FIT_BEST    = 2'd1,
    FIT_FIRST   = 2'd2,
    FIT_WORST   = 2'd3
  } fit_e;

  typedef enum logic {
    REG_DISK   = 1'b0,
    REG_HEADER = 1'b1
  } reg_e;

  typedef struct packed {
    logic capture;
    logic check;
    logic walk;
    logic eval;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic chk_fail;
    logic walk_done;
  } stat_t;

endpackage

/* hw/rtl/ptfa_ctrl.sv */
// Controller state machine that sequences checks, the gap walk and result delivery.
module ptfa_ctrl
  import ptfa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_WALK  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        cmd_o.eval = 1'b1;
        if (stat_i.chk_fail) begin
          state_d = S_DONE;
        end else if (stat_i.walk_done) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`include "partition_table_fit_allocator_unit_assert.svh"

  `PTFA_ASSERT_NEXT(a_accept_to_check, in_valid_i && in_ready_o, state_q == S_CHECK, "accepted beat did not start checks")
  `PTFA_ASSERT(a_load_when_free, !cmd_o.load_out || out_free, "result overwrote a pending beat")
  `PTFA_ASSERT_NEXT(a_walk_to_eval, state_q == S_WALK && !stat_i.chk_fail && stat_i.walk_done, state_q == S_EVAL, "walk end not followed by evaluation")

endmodule

/* hw/rtl/ptfa_dp.sv */
// Datapath with the partition table, request checks, entry ranking and gap fitting.
module ptfa_dp
  import ptfa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  logic [DISK_W-1:0]      disk_i,
  input  logic [HDR_W-1:0]       header_i,
  input  logic [SIZE_W-1:0]      size_value_i,
  input  logic [1:0]             size_unit_i,
  input  logic [1:0]             part_kind_i,
  input  logic [1:0]             fit_policy_i,
  input  logic [NAME_LO_W-1:0]   name_low_i,
  input  logic [NAME_HI_W-1:0]   name_high_i,
  output logic [3:0]             status_o,
  output logic [OFFSET_BITS-1:0] placed_start_o,
  output logic [SLOT_W-1:0]      slot_index_o
);

  localparam int NAME_BYTES = (NAME_LO_W + NAME_HI_W) / 8;

  logic                   used_q  [TABLE_SLOTS];
  logic                   ext_q   [TABLE_SLOTS];
  logic [OFFSET_BITS-1:0] start_q [TABLE_SLOTS];
  logic [OFFSET_BITS-1:0] len_q   [TABLE_SLOTS];
  logic [NAME_LO_W-1:0]   nlo_q   [TABLE_SLOTS];
  logic [NAME_HI_W-1:0]   nhi_q   [TABLE_SLOTS];

  logic [SIZE_W-1:0]      size_q;
  unit_e                  unit_q;
  kind_e                  kind_q;
  fit_e                   fit_q;
  logic [NAME_LO_W-1:0]   rnlo_q;
  logic [NAME_HI_W-1:0]   rnhi_q;
  logic [NAME_LO_W-1:0]   cnlo;
  logic [NAME_HI_W-1:0]   cnhi;

  logic [SLOT_W-1:0]      rank_d [TABLE_SLOTS];
  logic [SLOT_W-1:0]      rank_q [TABLE_SLOTS];
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       n_used_q;
  logic [CNT_W-1:0]       step_q;
  logic                   ext_any, dup, free_any;
  logic [SLOT_W-1:0]      free_slot;
  logic [SLOT_W-1:0]      slot_q;
  status_e                chk_st;
  logic                   chk_fail_q;
  status_e                chk_st_q;
  logic [BYTE_W-1:0]      bytes;

  logic [OFFSET_BITS:0]   cur_q, cur_d;
  logic                   gap_valid_q, gap_valid_d;
  logic [OFFSET_BITS-1:0] gap_start_q, gap_start_d;
  logic [OFFSET_BITS-1:0] gap_size_q, gap_size_d;
  logic [OFFSET_BITS-1:0] sel_start, sel_len;
  logic [OFFSET_BITS:0]   s_ext, disk_ext;
  logic                   walk_last;

  logic                   found_q;
  logic [OFFSET_BITS-1:0] pick_q, best_q;
  logic                   fits, take;
  status_e                fin_st;

  logic [3:0]             st_out_q;
  logic [OFFSET_BITS-1:0] start_out_q;
  logic [SLOT_W-1:0]      slot_out_q;

  always_comb begin
    logic [NAME_BYTES*8-1:0] nm;
    logic keep;
    nm = {name_high_i, name_low_i};
    keep = 1'b1;
    for (int k = 0; k < NAME_BYTES; k++) begin
      keep = keep && (nm[k*8 +: 8] != 8'd0);
      if (!keep) nm[k*8 +: 8] = 8'd0;
    end
    cnlo = nm[NAME_LO_W-1:0];
    cnhi = nm[NAME_BYTES*8-1:NAME_LO_W];
  end

  always_comb begin
    case (unit_q)
      UNIT_BYTES: bytes = BYTE_W'(size_q);
      UNIT_KIB:   bytes = BYTE_W'(size_q) << UNIT_SHIFT;
      UNIT_MIB:   bytes = BYTE_W'(size_q) << (2 * UNIT_SHIFT);
      default:    bytes = '0;
    endcase
  end

  always_comb begin
    count     = '0;
    ext_any   = 1'b0;
    dup       = 1'b0;
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (used_q[i]) begin
        count = count + 1'b1;
        if (ext_q[i]) ext_any = 1'b1;
        if (nlo_q[i] == rnlo_q && nhi_q[i] == rnhi_q) dup = 1'b1;
      end else begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      rank_d[i] = '0;
      for (int j = 0; j < TABLE_SLOTS; j++) begin
        if (j != i && used_q[j] &&
            (start_q[j] < start_q[i] || (start_q[j] == start_q[i] && j < i))) begin
          rank_d[i] = rank_d[i] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (size_q == '0) begin
      chk_st = ST_BAD_SIZE;
    end else if (unit_q == UNIT_BAD) begin
      chk_st = ST_BAD_UNIT;
    end else if (kind_q == KIND_BAD) begin
      chk_st = ST_BAD_TYPE;
    end else if (kind_q == KIND_EXTENDED && ext_any) begin
      chk_st = ST_EXT_EXISTS;
    end else if (kind_q != KIND_LOGICAL && count >= CNT_W'(TABLE_SLOTS)) begin
      chk_st = ST_LIMIT;
    end else if (kind_q == KIND_LOGICAL && !ext_any) begin
      chk_st = ST_NO_EXT;
    end else if (kind_q == KIND_LOGICAL) begin
      chk_st = ST_LOGICAL;
    end else if (dup) begin
      chk_st = ST_DUPLICATE;
    end else if (!free_any) begin
      chk_st = ST_NO_SLOT;
    end else begin
      chk_st = ST_OK;
    end
  end

  always_comb begin
    sel_start = '0;
    sel_len   = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (used_q[i] && rank_q[i] == step_q[SLOT_W-1:0]) begin
        sel_start = start_q[i];
        sel_len   = len_q[i];
      end
    end
  end

  assign walk_last = (step_q == n_used_q);
  assign s_ext     = {1'b0, sel_start};
  assign disk_ext  = (OFFSET_BITS + 1)'(disk_i);

  always_comb begin
    cur_d       = cur_q;
    gap_valid_d = 1'b0;
    gap_start_d = cur_q[OFFSET_BITS-1:0];
    gap_size_d  = '0;
    if (walk_last) begin
      gap_valid_d = cur_q < disk_ext;
      gap_size_d  = OFFSET_BITS'(disk_ext - cur_q);
    end else begin
      gap_valid_d = s_ext > cur_q;
      gap_size_d  = OFFSET_BITS'(s_ext - cur_q);
      cur_d       = s_ext + {1'b0, sel_len};
    end
  end

  assign fits = CMP_W'(gap_size_q) >= CMP_W'(bytes);

  always_comb begin
    take = 1'b0;
    if (gap_valid_q && fits) begin
      if (!found_q) begin
        take = 1'b1;
      end else begin
        case (fit_q)
          FIT_FIRST: take = 1'b0;
          FIT_BEST:  take = gap_size_q < best_q;
          default:   take = gap_size_q > best_q;
        endcase
      end
    end
  end

  assign fin_st = chk_fail_q ? chk_st_q : (found_q ? ST_OK : ST_NO_SPACE);

  assign stat_o.chk_fail  = chk_fail_q;
  assign stat_o.walk_done = walk_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      size_q <= size_value_i;
      unit_q <= unit_e'(size_unit_i);
      kind_q <= kind_e'(part_kind_i);
      fit_q  <= fit_e'(fit_policy_i);
      rnlo_q <= cnlo;
      rnhi_q <= cnhi;
    end
    if (cmd_i.check) begin
      chk_st_q <= chk_st;
      slot_q   <= free_slot;
      n_used_q <= count;
      rank_q   <= rank_d;
      cur_q    <= (OFFSET_BITS + 1)'(header_i);
      step_q   <= '0;
    end else if (cmd_i.walk) begin
      cur_q  <= cur_d;
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.walk) begin
      gap_start_q <= gap_start_d;
      gap_size_q  <= gap_size_d;
    end
    if (take && cmd_i.eval) begin
      pick_q <= gap_start_q;
      best_q <= gap_size_q;
    end
    if (cmd_i.load_out) begin
      st_out_q    <= fin_st;
      start_out_q <= (fin_st == ST_OK) ? pick_q : '0;
      slot_out_q  <= (fin_st == ST_OK) ? slot_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_fail_q  <= 1'b0;
      gap_valid_q <= 1'b0;
      found_q     <= 1'b0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        used_q[i]  <= 1'b0;
        ext_q[i]   <= 1'b0;
        start_q[i] <= '0;
        len_q[i]   <= '0;
        nlo_q[i]   <= '0;
        nhi_q[i]   <= '0;
      end
    end else begin
      if (cmd_i.check) begin
        chk_fail_q  <= (chk_st != ST_OK);
        gap_valid_q <= 1'b0;
        found_q     <= 1'b0;
      end else begin
        if (cmd_i.walk) begin
          gap_valid_q <= gap_valid_d;
        end
        if (take && cmd_i.eval) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.load_out && fin_st == ST_OK) begin
        used_q[slot_q]  <= 1'b1;
        ext_q[slot_q]   <= (kind_q == KIND_EXTENDED);
        start_q[slot_q] <= pick_q;
        len_q[slot_q]   <= OFFSET_BITS'(bytes);
        nlo_q[slot_q]   <= rnlo_q;
        nhi_q[slot_q]   <= rnhi_q;
      end
    end
  end

  assign status_o       = st_out_q;
  assign placed_start_o = start_out_q;
  assign slot_index_o   = slot_out_q;

endmodule

/* hw/rtl/partition_table_fit_allocator_unit.sv */
// Top level of the partition table fit allocator with its configuration registers.
// The block keeps a table of TABLE_SLOTS partitions and answers one create request per
// input beat with one result beat. A request that fails its checks goes from the walk
// state straight to the result, skipping evaluation; an accepted check walks the used
// entries in start order, one per cycle, then the gap up to the disk end, and evaluates.
// A new request is taken once the previous one has moved into the output register.
// disk_bytes sits at address 0 and header_bytes at address 8, with 64-bit data.
module partition_table_fit_allocator_unit
  import ptfa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SIZE_W-1:0]      size_value_i,
  input  logic [1:0]             size_unit_i,
  input  logic [1:0]             part_kind_i,
  input  logic [1:0]             fit_policy_i,
  input  logic [NAME_LO_W-1:0]   name_low_i,
  input  logic [NAME_HI_W-1:0]   name_high_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [3:0]             status_o,
  output logic [OFFSET_BITS-1:0] placed_start_o,
  output logic [SLOT_W-1:0]      slot_index_o
);

  logic [DISK_W-1:0] disk_q;
  logic [HDR_W-1:0]  hdr_q;
  reg_e              reg_sel;
  logic              wr_en;
  cmd_t              cmd;
  stat_t             stat;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      REG_DISK:   prdata = APB_DATA_W'(disk_q);
      REG_HEADER: prdata = APB_DATA_W'(hdr_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_q <= '0;
      hdr_q  <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DISK:   disk_q <= pwdata[DISK_W-1:0];
        REG_HEADER: hdr_q  <= pwdata[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  ptfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ptfa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .disk_i         (disk_q),
    .header_i       (hdr_q),
    .size_value_i   (size_value_i),
    .size_unit_i    (size_unit_i),
    .part_kind_i    (part_kind_i),
    .fit_policy_i   (fit_policy_i),
    .name_low_i     (name_low_i),
    .name_high_i    (name_high_i),
    .status_o       (status_o),
    .placed_start_o (placed_start_o),
    .slot_index_o   (slot_index_o)
  );

endmodule
